// ===== design/agm_pkg.sv =====
`default_nettype none

package agm_pkg;

  localparam int PIX_W   = 8;
  localparam int GLYPH_W = 7;
  localparam int POS_W   = 10;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RENDER_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd3;

  localparam logic [2:0] MODE_CLASSIC  = 3'd0;
  localparam logic [2:0] MODE_INVERTED = 3'd1;
  localparam logic [2:0] MODE_EDGE_X   = 3'd2;
  localparam logic [2:0] MODE_EDGE_Y   = 3'd3;
  localparam logic [2:0] MODE_EDGE_XY  = 3'd4;

  localparam logic [CFG_W-1:0] RESET_WIDTH     = 11'd1024;
  localparam logic [CFG_W-1:0] RESET_HEIGHT    = 11'd1024;
  localparam logic [PIX_W-1:0] RESET_THRESHOLD = 8'd50;

  localparam logic [GLYPH_W-1:0] CH_SPACE = 7'h20;
  localparam logic [GLYPH_W-1:0] CH_BAR   = 7'h7C;
  localparam logic [GLYPH_W-1:0] CH_DASH  = 7'h2D;
  localparam logic [GLYPH_W-1:0] CH_PLUS  = 7'h2B;

  localparam int RAMP_LEN = 15;
  localparam logic [3:0] RAMP_LAST = 4'd14;

  // Reciprocal of 17 scaled by 4096; exact for every 8-bit sample.
  localparam logic [PIX_W-1:0] DIV17_MUL   = 8'd241;
  localparam int               DIV17_SHIFT = 12;

  localparam logic [GLYPH_W-1:0] RAMP_CLASSIC [RAMP_LEN] = '{
    7'h40, 7'h26, 7'h25, 7'h57, 7'h58, 7'h41, 7'h48, 7'h4F,
    7'h54, 7'h2A, 7'h5E, 7'h2B, 7'h2D, 7'h2E, 7'h20
  };

endpackage

`default_nettype wire

// ===== design/agm_if.sv =====
`default_nettype none

interface agm_pix_if import agm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface agm_glyph_if import agm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [GLYPH_W-1:0] glyph_code;
  logic [POS_W-1:0]   glyph_col;
  logic [POS_W-1:0]   glyph_row;
  logic               run_last;

  modport source (output valid, output glyph_code, output glyph_col, output glyph_row,
                  output run_last, input ready);
  modport sink (input valid, input glyph_code, input glyph_col, input glyph_row,
                input run_last, output ready);
endinterface

`default_nettype wire

// ===== design/agm_ram.sv =====
`default_nettype none

module agm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/ascii_edge_glyph_mapper_top.sv =====
`default_nettype none

// Channel   Dir  Payload                                        Handshake
// in_ch     in   pixel_value[7:0]                               valid/ready
// out_ch    out  glyph_code[6:0] glyph_col[9:0] glyph_row[9:0]  valid/ready
//                run_last
// cfg       in   cfg_index[1:0] cfg_wdata[10:0]                 cfg_we, no wait
//
// A request enters stage 1 the cycle after it is accepted, when both line buffer reads return.
// Stage 1 sends one result per cycle into the output register while out_ch does not stall, and a
// request releases up to three results, the most at the final column of the last row.
// An accepted pixel reaches out_ch through the stage 1 register and then the output register.
// Reset is synchronous; the line buffer needs no clearing pass.
// A stall on out_ch holds stage 1, which in turn drops in_ch.ready.
module ascii_edge_glyph_mapper_top import agm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  agm_pix_if.sink                   in_ch,
  agm_glyph_if.source               out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int MW  = (CW > RW) ? CW : RW;
  localparam int SW  = (MW + 1 > CFG_W) ? MW + 1 : CFG_W;
  localparam int CXW = (CW > POS_W) ? CW : POS_W;
  localparam int RXW = (RW > POS_W) ? RW : POS_W;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] prev_pix;
    logic [CW-1:0]    col;
    logic [RW-1:0]    row;
    logic             has_right;
    logic             fwd;
  } s1_item_t;

  logic [2:0]       mode_r;
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic [PIX_W-1:0] thr_r;

  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [PIX_W-1:0] prev_pix_r;

  logic             s1_valid_r;
  s1_item_t         s1_r;
  logic [2:0]       pend_r, pend_nxt;

  logic               out_valid_r;
  logic [GLYPH_W-1:0] out_code_r;
  logic [POS_W-1:0]   out_col_r;
  logic [POS_W-1:0]   out_row_r;
  logic               out_last_r;

  logic [SW-1:0]    w_eff, h_eff, col_ext, row_ext;
  logic [CW-1:0]    c_cur, rd_addr;
  logic [RW-1:0]    r_cur;
  logic             last_col, last_row;
  logic             in_fire, s1_load, out_load, s1_retire;
  logic [2:0]       pend_new;
  s1_item_t         s1_new;
  logic [PIX_W-1:0] ram_rdata, right_v, left_rdata;

  logic [PIX_W-1:0] g_origin, g_right, g_down;
  logic             g_has_right, g_has_down;
  logic [CW-1:0]    g_col;
  logic [RW-1:0]    g_row;
  logic [CXW-1:0]   g_col_x;
  logic [RXW-1:0]   g_row_x;
  logic [GLYPH_W-1:0] g_code;

  function automatic logic [GLYPH_W-1:0] pick_glyph(
    input logic [2:0]       mode,
    input logic [PIX_W-1:0] thr,
    input logic [PIX_W-1:0] origin,
    input logic [PIX_W-1:0] right,
    input logic             has_right,
    input logic [PIX_W-1:0] down,
    input logic             has_down
  );
    logic [PIX_W-1:0]   dx, dy;
    logic               ex, ey;
    logic [2*PIX_W-1:0] prod;
    logic [3:0]         q;
    logic [GLYPH_W-1:0] g;
    dx   = (origin > right) ? origin - right : right - origin;
    dy   = (origin > down) ? origin - down : down - origin;
    ex   = has_right && (dx >= thr);
    ey   = has_down && (dy >= thr);
    prod = origin * DIV17_MUL;
    q    = prod[DIV17_SHIFT +: 4];
    if (q > RAMP_LAST) begin
      q = RAMP_LAST;
    end
    case (mode)
      MODE_EDGE_X: g = ex ? CH_BAR : CH_SPACE;
      MODE_EDGE_Y: g = ey ? CH_DASH : CH_SPACE;
      MODE_EDGE_XY: begin
        if (ex && ey) begin
          g = CH_PLUS;
        end else if (ex) begin
          g = CH_BAR;
        end else if (ey) begin
          g = CH_DASH;
        end else begin
          g = CH_SPACE;
        end
      end
      MODE_INVERTED: g = RAMP_CLASSIC[RAMP_LAST - q];
      default: g = RAMP_CLASSIC[q];
    endcase
    return g;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_CLASSIC;
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      thr_r    <= RESET_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RENDER_MODE:    mode_r   <= cfg_wdata[2:0];
        REG_IMAGE_WIDTH:    width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT:   height_r <= cfg_wdata;
        REG_EDGE_THRESHOLD: thr_r    <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective size and position of the incoming pixel.
  always_comb begin
    if (width_r == '0) begin
      w_eff = SW'(1);
    end else if (SW'(width_r) > SW'(MAX_WIDTH)) begin
      w_eff = SW'(MAX_WIDTH);
    end else begin
      w_eff = SW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = SW'(1);
    end else if (SW'(height_r) > SW'(MAX_HEIGHT)) begin
      h_eff = SW'(MAX_HEIGHT);
    end else begin
      h_eff = SW'(height_r);
    end

    col_ext = SW'(col_r);
    row_ext = SW'(row_r);
    if (col_ext >= w_eff) begin
      col_ext = '0;
      row_ext = row_ext + SW'(1);
    end
    if (row_ext >= h_eff) begin
      row_ext = '0;
    end
    c_cur = col_ext[CW-1:0];
    r_cur = row_ext[RW-1:0];

    last_col = (SW'(c_cur) == w_eff - SW'(1));
    last_row = (SW'(r_cur) == h_eff - SW'(1));
    rd_addr  = last_col ? '0 : c_cur + CW'(1);

    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : r_cur + RW'(1);
    end else begin
      col_nxt = c_cur + CW'(1);
      row_nxt = r_cur;
    end

    pend_new = {last_row && last_col, last_row && (c_cur != '0), r_cur != '0};

    s1_new.pix       = in_ch.pixel_value;
    s1_new.prev_pix  = prev_pix_r;
    s1_new.col       = c_cur;
    s1_new.row       = r_cur;
    s1_new.has_right = !last_col;
    s1_new.fwd       = (rd_addr == c_cur);
  end

  agm_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (in_fire),
    .waddr (c_cur),
    .wdata (in_ch.pixel_value),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Second copy of the line buffer reads the row above at the pixel's own column.
  agm_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_buf_left (
    .clk   (clk),
    .we    (in_fire),
    .waddr (c_cur),
    .wdata (in_ch.pixel_value),
    .re    (in_fire),
    .raddr (c_cur),
    .rdata (left_rdata)
  );

  // Stage 1 sends its pending results in order: row above, delayed pixel, final column.
  always_comb begin
    right_v  = s1_r.fwd ? s1_r.pix : ram_rdata;
    out_load = s1_valid_r && (pend_r != '0) && (!out_valid_r || out_ch.ready);
    pend_nxt = pend_r & (pend_r - 3'd1);
    s1_retire = s1_valid_r && ((pend_r == '0) || (out_load && (pend_nxt == '0)));
    in_ch.ready = !s1_valid_r || s1_retire;
    in_fire  = in_ch.valid && in_ch.ready;
    s1_load  = in_fire;

    g_origin    = s1_r.pix;
    g_right     = '0;
    g_has_right = 1'b0;
    g_down      = '0;
    g_has_down  = 1'b0;
    g_col       = s1_r.col;
    g_row       = s1_r.row;
    if (pend_r[0]) begin
      g_origin    = left_rdata;
      g_right     = right_v;
      g_has_right = s1_r.has_right;
      g_down      = s1_r.pix;
      g_has_down  = 1'b1;
      g_row       = s1_r.row - RW'(1);
    end else if (pend_r[1]) begin
      g_origin    = s1_r.prev_pix;
      g_right     = s1_r.pix;
      g_has_right = 1'b1;
      g_col       = s1_r.col - CW'(1);
    end
    g_code  = pick_glyph(mode_r, thr_r, g_origin, g_right, g_has_right, g_down, g_has_down);
    g_col_x = CXW'(g_col);
    g_row_x = RXW'(g_row);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      prev_pix_r  <= '0;
      s1_valid_r  <= 1'b0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        prev_pix_r <= in_ch.pixel_value;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
        pend_r     <= pend_new;
      end else if (s1_retire) begin
        s1_valid_r <= 1'b0;
        pend_r     <= '0;
      end else if (out_load) begin
        pend_r <= pend_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r <= s1_new;
    end
    if (out_load) begin
      out_code_r <= g_code;
      out_col_r  <= g_col_x[POS_W-1:0];
      out_row_r  <= g_row_x[POS_W-1:0];
      out_last_r <= (pend_nxt == '0);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.glyph_code = out_code_r;
  assign out_ch.glyph_col  = out_col_r;
  assign out_ch.glyph_row  = out_row_r;
  assign out_ch.run_last   = out_last_r;

  a_fire_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted pixel did not reach stage 1");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_retire) |=> (s1_valid_r && $stable(s1_r.col) && $stable(s1_r.row)))
    else $error("stage 1 item changed before it retired");

  a_partial_run_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (s1_valid_r && (pend_r != '0)))
    else $error("non-final result without pending results in stage 1");

  a_pend_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !s1_retire) |=> ($countones(pend_r) == $countones($past(pend_r)) - 1))
    else $error("stage 1 pending mask did not drop one result");

endmodule

`default_nettype wire

// ===== test/tb_ascii_edge_glyph_mapper_top.sv =====
`timescale 1ns / 1ps

module tb_ascii_edge_glyph_mapper_top import agm_pkg::*; ();

  localparam int MAX_W         = 1024;
  localparam int RANDOM_ITEMS  = 240;
  localparam int CALM_AFTER    = 200;
  localparam int EXTREME_ITEMS = 40;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 120;
  localparam int QUIET_LIMIT   = 2000;

  localparam logic [2:0] MODE_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] MODE_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic [GLYPH_W-1:0] code;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               last;
  } glyph_t;

  typedef enum logic [1:0] {ST_WRITE, ST_PIXEL, ST_PIXEL_KNOWN} step_kind_e;

  typedef struct {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     value;
    logic [PIX_W-1:0]     pix;
    logic [GLYPH_W-1:0]   code;
  } step_t;

  localparam int PLAN_LEN = 40;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  agm_pix_if   pix_ch ();
  agm_glyph_if glyph_ch ();

  ascii_edge_glyph_mapper_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_ch),
    .out_ch    (glyph_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [2:0]       cur_mode      = MODE_CLASSIC;
  logic [CFG_W-1:0] cur_width     = RESET_WIDTH;
  logic [CFG_W-1:0] cur_height    = RESET_HEIGHT;
  logic [PIX_W-1:0] cur_threshold = RESET_THRESHOLD;

  int               col_pos    = 0;
  int               row_pos    = 0;
  logic [PIX_W-1:0] line_buf [MAX_W];
  logic [PIX_W-1:0] last_pixel = '0;

  string bright_ramp = "@&%WXAHOT*^+-. ";
  string dark_ramp   = " .-+^*TOHAXW%&@";

  glyph_t step_out [3];
  int     step_count;
  glyph_t pending_glyphs [$];

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  int  rand_items     = 0;
  bit  calm           = 1'b0;
  bit  tx_bursty      = 1'b1;
  bit  rx_bursty      = 1'b1;
  bit  hold_req       = 1'b0;
  bit  held_off       = 1'b0;
  int  stall_left     = 0;

  step_t plan [PLAN_LEN] = '{
    '{ST_PIXEL,       '0, '0, 8'd0,   '0},
    '{ST_PIXEL,       '0, '0, 8'd255, '0},
    '{ST_PIXEL,       '0, '0, 8'd128, '0},
    '{ST_WRITE,       REG_IMAGE_WIDTH, 11'd2, '0, '0},
    '{ST_PIXEL,       '0, '0, 8'd17,  '0},
    '{ST_WRITE,       REG_IMAGE_HEIGHT, 11'd2, '0, '0},
    '{ST_PIXEL,       '0, '0, 8'd200, '0},
    '{ST_WRITE,       REG_IMAGE_WIDTH, 11'd1, '0, '0},
    '{ST_WRITE,       REG_IMAGE_HEIGHT, 11'd1, '0, '0},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd0,   7'h40},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd16,  7'h40},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd17,  7'h26},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd237, 7'h2E},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd238, CH_SPACE},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd255, CH_SPACE},
    '{ST_WRITE,       REG_RENDER_MODE, {8'd0, MODE_INVERTED}, '0, '0},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd0,   CH_SPACE},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd255, 7'h40},
    '{ST_WRITE,       REG_RENDER_MODE, {8'd0, MODE_UNKNOWN_LO}, '0, '0},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd0,   7'h40},
    '{ST_WRITE,       REG_RENDER_MODE, {8'd0, MODE_UNKNOWN_HI}, '0, '0},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd255, CH_SPACE},
    '{ST_WRITE,       REG_RENDER_MODE, {8'd0, MODE_EDGE_X}, '0, '0},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd0,   CH_SPACE},
    '{ST_WRITE,       REG_RENDER_MODE, {8'd0, MODE_EDGE_Y}, '0, '0},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd255, CH_SPACE},
    '{ST_WRITE,       REG_RENDER_MODE, {8'd0, MODE_EDGE_XY}, '0, '0},
    '{ST_PIXEL_KNOWN, '0, '0, 8'd128, CH_SPACE},
    '{ST_WRITE,       REG_EDGE_THRESHOLD, 11'd0, '0, '0},
    '{ST_WRITE,       REG_IMAGE_WIDTH, 11'd2, '0, '0},
    '{ST_WRITE,       REG_IMAGE_HEIGHT, 11'd2, '0, '0},
    '{ST_PIXEL,       '0, '0, 8'd10,  '0},
    '{ST_PIXEL,       '0, '0, 8'd10,  '0},
    '{ST_PIXEL,       '0, '0, 8'd10,  '0},
    '{ST_PIXEL,       '0, '0, 8'd10,  '0},
    '{ST_WRITE,       REG_EDGE_THRESHOLD, 11'd255, '0, '0},
    '{ST_PIXEL,       '0, '0, 8'd0,   '0},
    '{ST_PIXEL,       '0, '0, 8'd255, '0},
    '{ST_PIXEL,       '0, '0, 8'd255, '0},
    '{ST_PIXEL,       '0, '0, 8'd0,   '0}
  };

  function automatic int clamp_size(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_W) return MAX_W;
    return int'(v);
  endfunction

  function automatic logic [GLYPH_W-1:0] pick_char(logic [PIX_W-1:0] origin,
                                                   logic [PIX_W-1:0] right, bit has_right,
                                                   logic [PIX_W-1:0] down, bit has_down);
    int dx;
    int dy;
    int q;
    bit ex;
    bit ey;
    dx = (origin > right) ? origin - right : right - origin;
    dy = (origin > down) ? origin - down : down - origin;
    ex = has_right && (dx >= cur_threshold);
    ey = has_down && (dy >= cur_threshold);
    case (cur_mode)
      MODE_EDGE_X: return ex ? CH_BAR : CH_SPACE;
      MODE_EDGE_Y: return ey ? CH_DASH : CH_SPACE;
      MODE_EDGE_XY: begin
        if (ex && ey) return CH_PLUS;
        if (ex) return CH_BAR;
        if (ey) return CH_DASH;
        return CH_SPACE;
      end
      default: begin
        q = origin / 17;
        if (q > 14) q = 14;
        if (cur_mode == MODE_INVERTED) return GLYPH_W'(dark_ramp[q]);
        return GLYPH_W'(bright_ramp[q]);
      end
    endcase
  endfunction

  function automatic glyph_t make_glyph(logic [GLYPH_W-1:0] code, int c, int r);
    glyph_t g;
    g.code = code;
    g.col  = c[POS_W-1:0];
    g.row  = r[POS_W-1:0];
    g.last = 1'b0;
    return g;
  endfunction

  // Advances the raster position by one pixel and leaves the glyphs it releases in step_out.
  task automatic map_pixel(input logic [PIX_W-1:0] p);
    int w;
    int h;
    int c;
    int r;
    bit has_right;
    w = clamp_size(cur_width);
    h = clamp_size(cur_height);
    step_count = 0;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    if (r >= 1) begin
      has_right = (c + 1) < w;
      step_out[step_count] = make_glyph(pick_char(line_buf[c],
                                                  has_right ? line_buf[c + 1] : 8'd0,
                                                  has_right, p, 1'b1), c, r - 1);
      step_count++;
    end
    if (r == h - 1) begin
      if (c >= 1) begin
        step_out[step_count] = make_glyph(pick_char(last_pixel, p, 1'b1, 8'd0, 1'b0),
                                          c - 1, r);
        step_count++;
      end
      if (c == w - 1) begin
        step_out[step_count] = make_glyph(pick_char(p, 8'd0, 1'b0, 8'd0, 1'b0), c, r);
        step_count++;
      end
    end
    if (step_count > 0) step_out[step_count - 1].last = 1'b1;
    line_buf[c] = p;
    last_pixel = p;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  function automatic logic [PIX_W-1:0] next_pixel();
    int v;
    int idx;
    idx = (col_pos < MAX_W) ? col_pos : 0;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 1) ? 255 : 0;
      1: v = last_pixel + cur_threshold;
      2: v = last_pixel - cur_threshold;
      3: v = line_buf[idx] + cur_threshold;
      4: v = line_buf[idx] - cur_threshold;
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  function automatic int pick_size(int top);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return $urandom_range(top / 2, top);
      default: return $urandom_range(2, 6);
    endcase
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 255;
      2: return $urandom_range(0, 255);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] p, input bit known,
                            input logic [GLYPH_W-1:0] known_code);
    glyph_t g;
    @(negedge clk);
    if (!calm && tx_bursty && $urandom_range(0, 2) == 0) begin
      pix_ch.valid = 1'b0;
      pix_ch.pixel_value = PIX_W'($urandom_range(0, 255));
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    if ($urandom_range(0, 29) == 0) tx_bursty = !tx_bursty;
    pix_ch.valid = 1'b1;
    pix_ch.pixel_value = p;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    map_pixel(p);
    if (known) begin
      g.code = known_code;
      g.col  = '0;
      g.row  = '0;
      g.last = 1'b1;
      pending_glyphs.push_back(g);
    end else begin
      for (int k = 0; k < step_count; k++) pending_glyphs.push_back(step_out[k]);
    end
  endtask

  task automatic run_pixels(input int count, input bit counted);
    for (int i = 0; i < count; i++) begin
      send_pixel(next_pixel(), 1'b0, '0);
      if (counted) begin
        rand_items++;
        if (rand_items >= CALM_AFTER) calm = 1'b1;
      end
    end
  endtask

  // Registers may change only once the block has drained every pending request.
  task automatic settle();
    @(negedge clk);
    pix_ch.valid = 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_RENDER_MODE:    cur_mode = value[2:0];
      REG_IMAGE_WIDTH:    cur_width = value;
      REG_IMAGE_HEIGHT:   cur_height = value;
      REG_EDGE_THRESHOLD: cur_threshold = value[PIX_W-1:0];
      default: ;
    endcase
  endtask

  initial begin
    glyph_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_off && hold_req) begin
        held_off = 1'b1;
        glyph_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (stall_left > 0) begin
        glyph_ch.ready = 1'b0;
        stall_left--;
      end else if (!calm && rx_bursty && $urandom_range(0, 2) == 0) begin
        glyph_ch.ready = 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        glyph_ch.ready = 1'b1;
      end
      if ($urandom_range(0, 29) == 0) rx_bursty = !rx_bursty;
    end
  end

  always @(posedge clk) begin
    glyph_t got;
    glyph_t want;
    if (rst_n && glyph_ch.valid && glyph_ch.ready) begin
      got.code = glyph_ch.glyph_code;
      got.col  = glyph_ch.glyph_col;
      got.row  = glyph_ch.glyph_row;
      got.last = glyph_ch.run_last;
      if (pending_glyphs.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected glyph code %0d col %0d row %0d last %0d",
                 $time, got.code, got.col, got.row, got.last);
      end else begin
        want = pending_glyphs.pop_front();
        if (got.code !== want.code || got.col !== want.col || got.row !== want.row ||
            got.last !== want.last) begin
          mismatch_count++;
          $display("%0t: expected code/col/row/last %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                   $time, want.code, want.col, want.row, want.last,
                   got.code, got.col, got.row, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (pix_ch.valid && pix_ch.ready) || (glyph_ch.valid && glyph_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int  new_w;
    int  new_h;
    int  wpix;
    int  hpix;
    int  count;
    bit  at_start;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_value = '0;
    foreach (line_buf[i]) line_buf[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ST_WRITE: begin
          settle();
          write_reg(plan[i].idx, plan[i].value);
        end
        ST_PIXEL:       send_pixel(plan[i].pix, 1'b0, '0);
        ST_PIXEL_KNOWN: send_pixel(plan[i].pix, 1'b1, plan[i].code);
        default: ;
      endcase
    end

    // Oversized and zero sizes clamp to the limits; the receiver holds off during the column.
    settle();
    write_reg(REG_RENDER_MODE, CFG_W'($urandom_range(0, 4)));
    write_reg(REG_EDGE_THRESHOLD, CFG_W'($urandom_range(0, 255)));
    write_reg(REG_IMAGE_WIDTH, 11'h7FF);
    write_reg(REG_IMAGE_HEIGHT, 11'd1);
    run_pixels(EXTREME_ITEMS, 1'b0);
    settle();
    write_reg(REG_RENDER_MODE, CFG_W'($urandom_range(0, 4)));
    write_reg(REG_IMAGE_WIDTH, 11'd0);
    write_reg(REG_IMAGE_HEIGHT, 11'h7FF);
    hold_req = 1'b1;
    run_pixels(EXTREME_ITEMS, 1'b0);

    while (rand_items < RANDOM_ITEMS) begin
      settle();
      at_start = (col_pos == 0 && row_pos == 0);
      write_reg(REG_RENDER_MODE, CFG_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 4)
                                                                    : $urandom_range(5, 7)));
      write_reg(REG_EDGE_THRESHOLD, CFG_W'(pick_threshold()));
      // Within an image the width never grows, so no unwritten line entry is read.
      if (at_start) begin
        new_w = pick_size(20);
      end else begin
        wpix = clamp_size(cur_width);
        new_w = $urandom_range(0, (wpix < 12) ? wpix : 12);
      end
      new_h = pick_size(8);
      write_reg(REG_IMAGE_WIDTH, CFG_W'(new_w));
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(new_h));
      wpix = clamp_size(CFG_W'(new_w));
      hpix = clamp_size(CFG_W'(new_h));
      if (at_start && $urandom_range(0, 4) != 0) count = wpix * hpix;
      else count = $urandom_range(1, (wpix * hpix < 30) ? wpix * hpix : 30);
      run_pixels(count, 1'b1);
    end

    @(negedge clk);
    pix_ch.valid = 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
